FILE: sv/assert_macros.svh
// Assertion macros shared by the resolver RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NDP_ASSERT_IMPL(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("ndp assertion failed");

// Next-cycle implication, disabled during reset.
`define NDP_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("ndp assertion failed");

`endif

FILE: sv/ndp_pkg.sv
// Shared constants, beat codes and structs of the NDP advert MAC resolver.
// No dependencies; used by ndp_parser, ndp_table and the top level.
package ndp_pkg;

    // table and message sizing
    localparam int ENTRIES     = 16;
    localparam int MAX_MESSAGE = 1024;
    localparam int ENT_AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OFF_W       = $clog2(MAX_MESSAGE + 1);
    localparam int OPT_W       = $clog2(MAX_MESSAGE + 256);
    localparam int SUM_W       = OPT_W + 1;

    // field widths
    localparam int IDX_W  = 4;
    localparam int ADDR_W = 64;
    localparam int MAC_W  = 48;
    localparam int MASK_W = 16;
    localparam int HOST_W = 2 * ADDR_W;

    // protocol constants
    localparam logic [7:0] ADVERT_TYPE = 8'd136;
    localparam logic [7:0] TLLA_TYPE   = 8'd2;
    localparam int         OPTIONS_AT  = 24;
    localparam int         MIN_MSG     = 8;
    localparam int         TLLA_MIN    = 8;

    // input kinds
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // result kinds
    localparam logic RES_REPORT = 1'b0;
    localparam logic RES_READ   = 1'b1;

    // one accepted input beat
    typedef struct packed {
        logic              valid;
        logic [1:0]        kind;
        logic [IDX_W-1:0]  idx;
        logic [7:0]        byte_value;
        logic              last;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
    } t_cmd;

    // end-of-message verdict from the option walker
    typedef struct packed {
        logic             ok;
        logic [MAC_W-1:0] mac;
    } t_pkt_end;

    // one result item
    typedef struct packed {
        logic              kind;
        logic              resolved;
        logic [MAC_W-1:0]  mac;
        logic [MASK_W-1:0] mask;
        logic              responded;
    } t_result;

endpackage

FILE: sv/ndp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ndp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/ndp_parser.sv
// Byte-wise ICMPv6 option walker: tracks message type and the type/length
// option chain, captures the target link-layer MAC. Depends on ndp_pkg.
module ndp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output ndp_pkg::t_pkt_end o_end
);

    logic [ndp_pkg::OFF_W-1:0] r_offset, n_offset, w_offset;
    logic [ndp_pkg::OPT_W-1:0] r_opt_start, n_opt_start, w_opt_start;
    logic [7:0]                r_opt_len, n_opt_len, w_opt_len;
    logic [7:0]                r_opt_type, n_opt_type, w_opt_type;
    logic                      r_stopped, n_stopped, w_stopped;
    logic                      r_found, n_found, w_found;
    logic [ndp_pkg::MAC_W-1:0] r_mac, n_mac, w_mac;
    logic [7:0]                r_msg_type, n_msg_type, w_msg_type;

    logic                      w_take;
    logic [ndp_pkg::SUM_W-1:0] w_pos;
    logic [ndp_pkg::SUM_W-1:0] w_start_x;
    logic [ndp_pkg::SUM_W-1:0] w_cap_start;

    // walk step for one byte
    always_comb begin
        w_offset    = r_offset;
        w_opt_start = r_opt_start;
        w_opt_len   = r_opt_len;
        w_opt_type  = r_opt_type;
        w_stopped   = r_stopped;
        w_found     = r_found;
        w_mac       = r_mac;
        w_msg_type  = r_msg_type;
        w_take      = i_valid && (r_offset < ndp_pkg::OFF_W'(ndp_pkg::MAX_MESSAGE));
        w_pos       = ndp_pkg::SUM_W'(r_offset);
        w_start_x   = ndp_pkg::SUM_W'(r_opt_start);
        w_cap_start = '0;
        if (w_take) begin
            if (r_offset == '0) begin
                w_msg_type = i_byte;
            end
            if (!r_stopped && !r_found && (w_pos >= ndp_pkg::SUM_W'(ndp_pkg::OPTIONS_AT))) begin
                if (w_pos == w_start_x) begin
                    w_opt_type = i_byte;
                end else if (w_pos == w_start_x + ndp_pkg::SUM_W'(1)) begin
                    // length in bytes, wrapped to 8 bits
                    w_opt_len = {i_byte[4:0], 3'b000};
                    if (w_opt_len == 8'd0) begin
                        w_stopped = 1'b1;
                    end else if (r_opt_type == ndp_pkg::TLLA_TYPE) begin
                        if (w_opt_len < 8'(ndp_pkg::TLLA_MIN)) begin
                            w_stopped = 1'b1;
                        end else begin
                            w_found = 1'b1;
                        end
                    end else begin
                        w_opt_start = r_opt_start + ndp_pkg::OPT_W'(w_opt_len);
                    end
                end
            end
            // MAC bytes sit at option offsets two to seven
            w_cap_start = ndp_pkg::SUM_W'(w_opt_start);
            if (w_found && (w_pos >= w_cap_start + ndp_pkg::SUM_W'(2))
                    && (w_pos <= w_cap_start + ndp_pkg::SUM_W'(7))) begin
                w_mac = {r_mac[ndp_pkg::MAC_W-9:0], i_byte};
            end
            w_offset = r_offset + ndp_pkg::OFF_W'(1);
        end
    end

    // verdict at the final byte
    always_comb begin
        o_end.ok  = (w_offset >= ndp_pkg::OFF_W'(ndp_pkg::MIN_MSG))
                 && (w_msg_type == ndp_pkg::ADVERT_TYPE) && w_found
                 && (ndp_pkg::SUM_W'(w_offset)
                     >= ndp_pkg::SUM_W'(w_opt_start) + ndp_pkg::SUM_W'(w_opt_len));
        o_end.mac = w_mac;
    end

    // the final byte returns the walk to its start
    always_comb begin
        if (i_valid && i_last) begin
            n_offset    = '0;
            n_opt_start = ndp_pkg::OPT_W'(ndp_pkg::OPTIONS_AT);
            n_opt_len   = '0;
            n_opt_type  = '0;
            n_stopped   = 1'b0;
            n_found     = 1'b0;
            n_mac       = '0;
            n_msg_type  = '0;
        end else begin
            n_offset    = w_offset;
            n_opt_start = w_opt_start;
            n_opt_len   = w_opt_len;
            n_opt_type  = w_opt_type;
            n_stopped   = w_stopped;
            n_found     = w_found;
            n_mac       = w_mac;
            n_msg_type  = w_msg_type;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_opt_start <= ndp_pkg::OPT_W'(ndp_pkg::OPTIONS_AT);
            r_opt_len   <= '0;
            r_opt_type  <= '0;
            r_stopped   <= 1'b0;
            r_found     <= 1'b0;
            r_mac       <= '0;
            r_msg_type  <= '0;
        end else begin
            r_offset    <= n_offset;
            r_opt_start <= n_opt_start;
            r_opt_len   <= n_opt_len;
            r_opt_type  <= n_opt_type;
            r_stopped   <= n_stopped;
            r_found     <= n_found;
            r_mac       <= n_mac;
            r_msg_type  <= n_msg_type;
        end
    end

endmodule

FILE: sv/ndp_table.sv
// Request table: host and MAC RAMs, valid/responded flags, and the sequencer
// for loads, reads and the end-of-packet match scan. Depends on ndp_pkg, ndp_ram.
`include "assert_macros.svh"

module ndp_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ndp_pkg::t_cmd     i_cmd,
    input  ndp_pkg::t_pkt_end i_end,
    output logic              o_idle,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output ndp_pkg::t_result  o_res
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    logic [ndp_pkg::ENT_AW-1:0] r_cnt, n_cnt;
    logic [ndp_pkg::MASK_W-1:0] r_mask, n_mask;
    ndp_pkg::t_result           r_res, n_res;
    logic [ndp_pkg::HOST_W-1:0] r_sender, n_sender;
    logic [ndp_pkg::MAC_W-1:0]  r_cap_mac, n_cap_mac;
    logic                       r_rd_ok, n_rd_ok;
    logic [ndp_pkg::ENTRIES-1:0] r_valid, n_valid;
    logic [ndp_pkg::ENTRIES-1:0] r_resp, n_resp;

    logic                       w_in_range;
    logic [ndp_pkg::ENT_AW-1:0] w_idx;
    logic                       w_cnt_last;
    logic                       w_hit;

    logic                       w_host_wr, w_host_rd;
    logic [ndp_pkg::ENT_AW-1:0] w_host_rd_addr;
    logic [ndp_pkg::HOST_W-1:0] w_host_q;
    logic                       w_mac_wr, w_mac_rd;
    logic [ndp_pkg::MAC_W-1:0]  w_mac_q;

    assign w_in_range = (32'(i_cmd.idx) < ndp_pkg::ENTRIES);
    assign w_idx      = ndp_pkg::ENT_AW'(i_cmd.idx);
    assign w_cnt_last = (r_cnt == ndp_pkg::ENT_AW'(ndp_pkg::ENTRIES - 1));
    assign w_hit      = (r_state == ST_SCAN) && r_valid[r_cnt] && !r_resp[r_cnt]
                     && (w_host_q == r_sender);

    // host addresses, written by loads, swept by the scan
    ndp_ram #(
        .WIDTH (ndp_pkg::HOST_W),
        .DEPTH (ndp_pkg::ENTRIES)
    ) u_host_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_host_wr),
        .i_wr_addr (w_idx),
        .i_wr_data ({i_cmd.addr_high, i_cmd.addr_low}),
        .i_rd_en   (w_host_rd),
        .i_rd_addr (w_host_rd_addr),
        .o_rd_data (w_host_q)
    );

    // resolved MACs, written by the scan, read by read items
    ndp_ram #(
        .WIDTH (ndp_pkg::MAC_W),
        .DEPTH (ndp_pkg::ENTRIES)
    ) u_mac_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_mac_wr),
        .i_wr_addr (r_cnt),
        .i_wr_data (r_cap_mac),
        .i_rd_en   (w_mac_rd),
        .i_rd_addr (w_idx),
        .o_rd_data (w_mac_q)
    );

    // sequencer
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_mask         = r_mask;
        n_res          = r_res;
        n_sender       = r_sender;
        n_cap_mac      = r_cap_mac;
        n_rd_ok        = r_rd_ok;
        n_valid        = r_valid;
        n_resp         = r_resp;
        w_host_wr      = 1'b0;
        w_host_rd      = 1'b0;
        w_host_rd_addr = '0;
        w_mac_wr       = 1'b0;
        w_mac_rd       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    case (i_cmd.kind)
                        ndp_pkg::KIND_LOAD: begin
                            if (w_in_range) begin
                                w_host_wr      = 1'b1;
                                n_valid[w_idx] = 1'b1;
                                n_resp[w_idx]  = 1'b0;
                            end
                        end
                        ndp_pkg::KIND_READ: begin
                            w_mac_rd = w_in_range;
                            n_rd_ok  = w_in_range && r_resp[w_idx];
                            n_state  = ST_READ;
                        end
                        ndp_pkg::KIND_BYTE: begin
                            if (i_cmd.last) begin
                                if (i_end.ok) begin
                                    n_sender       = {i_cmd.addr_high, i_cmd.addr_low};
                                    n_cap_mac      = i_end.mac;
                                    n_cnt          = '0;
                                    n_mask         = '0;
                                    w_host_rd      = 1'b1;
                                    w_host_rd_addr = '0;
                                    n_state        = ST_SCAN;
                                end else begin
                                    n_res   = '0;
                                    n_state = ST_DONE;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                // unresolved entries read back a zero MAC
                n_res.kind      = ndp_pkg::RES_READ;
                n_res.resolved  = 1'b0;
                n_res.mac       = r_rd_ok ? w_mac_q : '0;
                n_res.mask      = '0;
                n_res.responded = r_rd_ok;
                n_state         = ST_DONE;
            end
            ST_SCAN: begin
                // compare entry r_cnt, prefetch the next host address
                if (w_hit) begin
                    w_mac_wr       = 1'b1;
                    n_resp[r_cnt]  = 1'b1;
                    n_mask         = r_mask | (ndp_pkg::MASK_W'(1) << r_cnt);
                end
                if (w_cnt_last) begin
                    n_res.kind      = ndp_pkg::RES_REPORT;
                    n_res.resolved  = 1'b1;
                    n_res.mac       = r_cap_mac;
                    n_res.mask      = n_mask;
                    n_res.responded = 1'b0;
                    n_state         = ST_DONE;
                end else begin
                    w_host_rd      = 1'b1;
                    w_host_rd_addr = r_cnt + ndp_pkg::ENT_AW'(1);
                    n_cnt          = r_cnt + ndp_pkg::ENT_AW'(1);
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_resp  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_resp  <= n_resp;
            r_cnt   <= n_cnt;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_mask    <= n_mask;
        r_res     <= n_res;
        r_sender  <= n_sender;
        r_cap_mac <= n_cap_mac;
        r_rd_ok   <= n_rd_ok;
    end

    assign o_idle      = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

    `NDP_ASSERT_NEXT(a_scan_ends, (r_state == ST_SCAN) && w_cnt_last, r_state == ST_DONE)
    `NDP_ASSERT_IMPL(a_report_clean, (r_state == ST_DONE) && (r_res.kind == ndp_pkg::RES_REPORT) && !r_res.resolved, (r_res.mask == '0) && (r_res.mac == '0))
    `NDP_ASSERT_NEXT(a_hit_sets_flag, w_hit, r_resp[$past(r_cnt)])

endmodule

FILE: sv/ndp_advert_mac_resolver_top.sv
// Top level of the NDP advert MAC resolver: stream ports, beat decode and the
// output register. Depends on ndp_pkg, ndp_parser, ndp_table.
`include "assert_macros.svh"

// Packet bytes and loads: one beat per cycle, no result for non-final bytes.
// Read: reply passes the MAC RAM read, ST_READ and ST_DONE into the output register.
// Final byte of a resolving advert: scan of the host RAM, one entry per cycle,
// then the report through ST_DONE; other final bytes go straight to ST_DONE.
// Input is held off while a read or scan runs or a result waits for the output.
// Reset (synchronous, active low) clears valid/responded flags and the walk; RAMs keep contents.
module ndp_advert_mac_resolver_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input beat
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: entry_index[3:0], byte_value[11:4], addr_high[75:12],
    //        addr_low[139:76], zero pad[143:140]
    input  logic [143:0] s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]   s_axis_tuser,
    // tlast: last_byte
    input  logic         s_axis_tlast,
    // result beat
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: resolved[0], mac_address[48:1], match_mask[64:49],
    //        entry_responded[65], zero pad[71:66]
    output logic [71:0]  m_axis_tdata,
    // tuser: result_kind
    output logic         m_axis_tuser
);

    ndp_pkg::t_cmd     w_cmd;
    ndp_pkg::t_pkt_end w_end;
    ndp_pkg::t_result  w_res;
    logic              w_idle;
    logic              w_res_valid;
    logic              w_res_ready;

    logic              r_out_valid, n_out_valid;
    ndp_pkg::t_result  r_out, n_out;

    // beat decode
    always_comb begin
        w_cmd.valid      = s_axis_tvalid && s_axis_tready;
        w_cmd.kind       = s_axis_tuser;
        w_cmd.idx        = s_axis_tdata[3:0];
        w_cmd.byte_value = s_axis_tdata[11:4];
        w_cmd.last       = s_axis_tlast;
        w_cmd.addr_high  = s_axis_tdata[75:12];
        w_cmd.addr_low   = s_axis_tdata[139:76];
    end

    assign s_axis_tready = w_idle;

    ndp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cmd.valid && (w_cmd.kind == ndp_pkg::KIND_BYTE)),
        .i_byte  (w_cmd.byte_value),
        .i_last  (w_cmd.last),
        .o_end   (w_end)
    );

    ndp_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_end       (w_end),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // output register
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_res_valid && w_res_ready) begin
            n_out_valid = 1'b1;
            n_out       = w_res;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {6'b000000, r_out.responded, r_out.mask, r_out.mac, r_out.resolved};

    `NDP_ASSERT_NEXT(a_out_loaded, w_res_valid && w_res_ready, r_out_valid)
    `NDP_ASSERT_IMPL(a_ready_no_pending, s_axis_tready, !w_res_valid)

endmodule
